[rtl/core/spbc_pkg.sv]
// shared constants, types and the cordic angle table for the bond classifier
package spbc_pkg;

    localparam int MAX_SITES_DEF   = 256;
    localparam int MAX_CLASSES_DEF = 8;

    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = 5;
    localparam int ACC_W        = 21;
    localparam int CORDIC_W     = 30;
    localparam int TILT_W       = 13;
    localparam logic [TILT_W-1:0] TILT_LIMIT = 13'd5760;

    // root widths: length root from a 34 bit sum, tilt height root from a 50 bit word
    localparam int LEN_RW = 17;
    localparam int HGT_RW = 25;

    localparam logic [1:0] OP_LOAD_SITE  = 2'd0;
    localparam logic [1:0] OP_LOAD_CLASS = 2'd1;
    localparam logic [1:0] OP_CLASSIFY   = 2'd2;
    localparam logic [1:0] OP_NONE       = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } site_t;

    typedef struct packed {
        logic [15:0]       dmin;
        logic [15:0]       dmax;
        logic [TILT_W-1:0] amin;
        logic [TILT_W-1:0] amax;
    } bclass_t;

    // atan(2^-i) in 1/4096 degree
    function automatic logic signed [ACC_W-1:0] atan_of(input logic [STEP_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 21'sd184320;
                5'd1:    v = 21'sd108810;
                5'd2:    v = 21'sd57492;
                5'd3:    v = 21'sd29184;
                5'd4:    v = 21'sd14649;
                5'd5:    v = 21'sd7331;
                5'd6:    v = 21'sd3667;
                5'd7:    v = 21'sd1833;
                5'd8:    v = 21'sd917;
                5'd9:    v = 21'sd458;
                5'd10:   v = 21'sd229;
                5'd11:   v = 21'sd115;
                5'd12:   v = 21'sd57;
                5'd13:   v = 21'sd29;
                5'd14:   v = 21'sd14;
                5'd15:   v = 21'sd7;
                5'd16:   v = 21'sd4;
                5'd17:   v = 21'sd2;
                default: v = 21'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/core/spbc_sqrt.sv]
// bit-serial integer square root, one result bit per cycle
module spbc_sqrt
    import spbc_pkg::*;
#(
    parameter int N = LEN_RW
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2*N-1:0] radicand,
    output logic           done,
    output logic [N-1:0]   root
);

    localparam int REM_W = N + 3;
    localparam int CNT_W = $clog2(N + 1);

    logic [2*N-1:0]   rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [N-1:0]     root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[2*N-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*N-3:0], 2'b00};
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[N-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/core/spbc_cordic.sv]
// iterative vectoring cordic giving the tilt angle, one rotation per cycle
module spbc_cordic
    import spbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [23:0]       x0,
    input  logic [HGT_RW-1:0] y0,
    output logic              done,
    output logic [TILT_W-1:0] tilt
);

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [STEP_W-1:0]          cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ACC_W-1:0]    ang;
    logic signed [ACC_W-1:0]    rnd;

    always_comb
    begin
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        ang = atan_of(cnt_reg);
        rnd = (acc_reg + ACC_W'(32)) >>> 6;
        if (acc_reg < 0)
            tilt = '0;
        else if (rnd > $signed({{(ACC_W-TILT_W){1'b0}}, TILT_LIMIT}))
            tilt = TILT_LIMIT;
        else
            tilt = rnd[TILT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= CORDIC_W'(x0);
            y_reg   <= CORDIC_W'(y0);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + ang;
            end
            else
            begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - ang;
            end
        end
    end

    assign done = done_reg;

endmodule

[rtl/core/site_pair_bond_classifier.sv]
// top level: site store, class table and the classify sequencer
//
// channel | signals                         | direction | word
// req     | req_valid, req_stall, fields    | in        | load or classify
// rsp     | rsp_valid, rsp_stall, fields    | out       | one per classify
// cfg     | cfg_we, cfg_wdata               | in        | classes_in_use
//
// loads leave the input free; a classify holds it until the sequencer idles again:
// through the 25 step height root, the 18 step cordic, a read and a check step per
// class entry searched and one more read when no entry fits the angle.
// z axis and xy plane pairs skip the cordic; a zero displacement skips the roots.
// the two roots run side by side; site reads use the one store port twice.
// reset clears control state only; store contents are undefined until loaded.
// a finished word waits in the output register while the next word is taken.
module site_pair_bond_classifier
    import spbc_pkg::*;
#(
    parameter int MAX_SITES   = MAX_SITES_DEF,
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  index_a,
    input  logic [7:0]  index_b,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [15:0] coord_z,
    input  logic [15:0] class_dmin,
    input  logic [15:0] class_dmax,
    input  logic [12:0] class_angle_min,
    input  logic [12:0] class_angle_max,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        is_bond,
    output logic [2:0]  bond_slot,
    output logic [15:0] bond_length,
    output logic [7:0]  first_site,
    output logic [7:0]  second_site
);

    localparam int SITE_AW = $clog2(MAX_SITES);
    localparam int CLS_AW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W   = $clog2(MAX_CLASSES + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD_B   = 4'd1;
    localparam logic [3:0] ST_DIFF   = 4'd2;
    localparam logic [3:0] ST_SQ     = 4'd3;
    localparam logic [3:0] ST_SUM    = 4'd4;
    localparam logic [3:0] ST_ROOT_GO = 4'd5;
    localparam logic [3:0] ST_ROOT   = 4'd6;
    localparam logic [3:0] ST_TILT   = 4'd7;
    localparam logic [3:0] ST_CLS_RD = 4'd8;
    localparam logic [3:0] ST_CLS_CK = 4'd9;
    localparam logic [3:0] ST_FIN    = 4'd10;

    function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        begin
            d = $signed({a[15], a}) - $signed({b[15], b});
            return d[16] ? 16'(-d) : d[15:0];
        end
    endfunction

    site_t   site_mem [MAX_SITES];
    bclass_t cls_mem  [MAX_CLASSES];
    site_t   site_rdata;
    bclass_t cls_rdata;
    logic [SITE_AW-1:0] site_raddr;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  cfg_reg;
    logic [CNT_W-1:0] n_cls;
    logic [CNT_W-1:0] cls_cnt_reg;

    logic [7:0]  ia_reg, ib_reg;
    logic        inrange_reg;
    site_t       a_reg;
    logic [15:0] ax_reg, ay_reg, az_reg;
    logic [31:0] sqx_reg, sqy_reg, sqz_reg;
    logic [32:0] hsq_reg;
    logic [33:0] dd_reg;
    logic [TILT_W-1:0] tilt_reg;
    logic        bond_reg;
    logic [CNT_W-1:0]  slot_reg;

    logic        accept;
    logic        out_free;
    logic        root_start;
    logic        cordic_start;
    logic        len_done, hgt_done, cordic_done;
    logic [LEN_RW-1:0] len_root;
    logic [HGT_RW-1:0] hgt_root;
    logic [TILT_W-1:0] cordic_tilt;
    logic [32:0] hsq_sum;
    logic        ang_hit, len_hit;

    logic        rsp_valid_reg;
    logic        is_bond_reg;
    logic [2:0]  bond_slot_reg;
    logic [15:0] bond_length_reg;
    logic [7:0]  first_site_reg, second_site_reg;

    assign accept    = req_valid && !req_stall;
    assign req_stall = state_reg != ST_IDLE;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign n_cls     = (32'(cfg_reg) > MAX_CLASSES) ? CNT_W'(MAX_CLASSES) : CNT_W'(cfg_reg);
    assign site_raddr = (state_reg == ST_IDLE) ? SITE_AW'(index_a) : SITE_AW'(ib_reg);
    assign hsq_sum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign ang_hit   = tilt_reg >= cls_rdata.amin && tilt_reg <= cls_rdata.amax;
    assign len_hit   = len_root >= LEN_RW'(cls_rdata.dmin) && len_root <= LEN_RW'(cls_rdata.dmax);
    assign root_start   = state_reg == ST_ROOT_GO;
    assign cordic_start = state_reg == ST_ROOT && len_done && hgt_done
                          && hsq_reg != '0 && az_reg != '0;

    // site store: one write and one read port
    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_LOAD_SITE && 32'(index_a) < MAX_SITES)
            site_mem[SITE_AW'(index_a)] <= '{x: coord_x, y: coord_y, z: coord_z};
        site_rdata <= site_mem[site_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_LOAD_CLASS && 32'(index_a) < MAX_CLASSES)
            cls_mem[CLS_AW'(index_a)] <= '{dmin: class_dmin, dmax: class_dmax,
                                          amin: class_angle_min, amax: class_angle_max};
        cls_rdata <= cls_mem[cls_cnt_reg[CLS_AW-1:0]];
    end

    spbc_sqrt #(.N(LEN_RW)) u_len_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (dd_reg),
        .done     (len_done),
        .root     (len_root)
    );

    spbc_sqrt #(.N(HGT_RW)) u_hgt_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand ({1'b0, hsq_reg, 16'b0}),
        .done     (hgt_done),
        .root     (hgt_root)
    );

    spbc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x0    ({az_reg, 8'b0}),
        .y0    (hgt_root),
        .done  (cordic_done),
        .tilt  (cordic_tilt)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && opcode == OP_CLASSIFY)
                    state_next = ST_RD_B;
            ST_RD_B:    state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_SQ;
            ST_SQ:      state_next = ST_SUM;
            ST_SUM:
                if (!inrange_reg || (hsq_sum == '0 && sqz_reg == '0))
                    state_next = ST_FIN;
                else
                    state_next = ST_ROOT_GO;
            ST_ROOT_GO: state_next = ST_ROOT;
            ST_ROOT:
                if (len_done && hgt_done)
                    state_next = cordic_start ? ST_TILT : ST_CLS_RD;
            ST_TILT:
                if (cordic_done)
                    state_next = ST_CLS_RD;
            ST_CLS_RD:
                state_next = (cls_cnt_reg >= n_cls) ? ST_FIN : ST_CLS_CK;
            ST_CLS_CK:
                state_next = ang_hit ? ST_FIN : ST_CLS_RD;
            ST_FIN:
                if (out_free)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (state_reg == ST_FIN && out_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                ia_reg      <= index_a;
                ib_reg      <= index_b;
                inrange_reg <= 32'(index_a) < MAX_SITES && 32'(index_b) < MAX_SITES;
                bond_reg    <= 1'b0;
                slot_reg    <= '0;
            end
            ST_RD_B: a_reg <= site_rdata;
            ST_DIFF:
            begin
                ax_reg <= abs_diff(a_reg.x, site_rdata.x);
                ay_reg <= abs_diff(a_reg.y, site_rdata.y);
                az_reg <= abs_diff(a_reg.z, site_rdata.z);
            end
            ST_SQ:
            begin
                sqx_reg <= 32'(ax_reg) * 32'(ax_reg);
                sqy_reg <= 32'(ay_reg) * 32'(ay_reg);
                sqz_reg <= 32'(az_reg) * 32'(az_reg);
            end
            ST_SUM:
            begin
                hsq_reg <= hsq_sum;
                dd_reg  <= {1'b0, hsq_sum} + {2'b0, sqz_reg};
            end
            ST_ROOT:
            begin
                cls_cnt_reg <= '0;
                // pair with no xy offset lies along z, pure xy pair lies at the right angle
                if (hsq_reg == '0)
                    tilt_reg <= '0;
                else if (az_reg == '0)
                    tilt_reg <= TILT_LIMIT;
            end
            ST_TILT:
                if (cordic_done)
                    tilt_reg <= cordic_tilt;
            ST_CLS_CK:
                // first entry whose angle range fits decides alone
                if (ang_hit)
                begin
                    bond_reg <= len_hit;
                    slot_reg <= cls_cnt_reg;
                end
                else
                    cls_cnt_reg <= cls_cnt_reg + 1'b1;
            ST_FIN:
                if (out_free)
                begin
                    is_bond_reg     <= bond_reg;
                    bond_slot_reg   <= bond_reg ? 3'(slot_reg) : 3'd0;
                    bond_length_reg <= bond_reg ? len_root[15:0] : 16'd0;
                    first_site_reg  <= ia_reg;
                    second_site_reg <= ib_reg;
                end
            default: ;
        endcase
    end

    assign rsp_valid   = rsp_valid_reg;
    assign is_bond     = is_bond_reg;
    assign bond_slot   = bond_slot_reg;
    assign bond_length = bond_length_reg;
    assign first_site  = first_site_reg;
    assign second_site = second_site_reg;

    a_word_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == ST_FIN)
        else $error("result word raised outside the finish step");

    a_no_bond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !is_bond |-> bond_slot == 3'd0 && bond_length == 16'd0)
        else $error("rejected pair carries class or length");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLS_CK |-> cls_cnt_reg < n_cls)
        else $error("class search ran past the entries in use");

    a_cordic_after_roots: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_start |-> len_done && hgt_done && hsq_reg != '0)
        else $error("tilt started before the roots were ready");

endmodule

[tb/bond_checker.sv]
// checker for the bond classifier: mirrors stores, predicts each answer word, compares
`timescale 1ns / 1ps
module bond_checker
    import spbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  index_a,
    input  logic [7:0]  index_b,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [15:0] coord_z,
    input  logic [15:0] class_dmin,
    input  logic [15:0] class_dmax,
    input  logic [12:0] class_angle_min,
    input  logic [12:0] class_angle_max,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic        is_bond,
    input  logic [2:0]  bond_slot,
    input  logic [15:0] bond_length,
    input  logic [7:0]  first_site,
    input  logic [7:0]  second_site,
    output int          fails,
    output int          pending,
    output int          bonds_seen
);

    typedef struct packed {
        logic        bond;
        logic [2:0]  slot;
        logic [15:0] length;
        logic [7:0]  site_a;
        logic [7:0]  site_b;
    } answer_t;

    localparam longint TILT_ATAN [CORDIC_STEPS] = '{
        184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833, 917,
        458, 229, 115, 57, 29, 14, 7, 4, 2
    };

    site_t   sites [MAX_SITES_DEF];
    bclass_t classes [MAX_CLASSES_DEF];
    logic [3:0] slots_used;
    answer_t answers_due [$];

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // tilt from z axis in 1/64 degree, vectoring cordic on (|dz|, xy length)
    function automatic int unsigned tilt_angle(input longint unsigned hsq,
                                               input longint unsigned az);
        longint x, y, xs, ys, acc;
        acc = 0;
        if (hsq == 0)
            return 0;
        if (az == 0)
            return TILT_LIMIT;
        y = longint'(floor_root(hsq << 16));
        x = longint'(az << 8);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; acc = acc + TILT_ATAN[i];
            end
            else
            begin
                x = x - ys; y = y + xs; acc = acc - TILT_ATAN[i];
            end
        end
        if (acc < 0)
            return 0;
        acc = (acc + 32) >>> 6;
        if (acc > TILT_LIMIT)
            acc = TILT_LIMIT;
        return int'(acc);
    endfunction

    function automatic answer_t classify_pair(input logic [7:0] ia, input logic [7:0] ib);
        answer_t a;
        longint dx, dy, dz;
        longint unsigned hsq, dd, len;
        int unsigned tilt, n;
        a = '0;
        a.site_a = ia;
        a.site_b = ib;
        dx = longint'(sites[ia].x) - longint'(sites[ib].x);
        dy = longint'(sites[ia].y) - longint'(sites[ib].y);
        dz = longint'(sites[ia].z) - longint'(sites[ib].z);
        if (dz < 0)
            dz = -dz;
        hsq = dx * dx + dy * dy;
        dd = hsq + dz * dz;
        if (dd == 0)
            return a;
        len = floor_root(dd);
        tilt = tilt_angle(hsq, dz);
        n = (slots_used > MAX_CLASSES_DEF) ? MAX_CLASSES_DEF : slots_used;
        for (int k = 0; k < n; k++)
        begin
            if (tilt >= classes[k].amin && tilt <= classes[k].amax)
            begin
                // only the first angle match decides
                if (len >= classes[k].dmin && len <= classes[k].dmax)
                begin
                    a.bond = 1'b1;
                    a.slot = k[2:0];
                    a.length = len[15:0];
                end
                break;
            end
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want, got;
        if (!rst_n)
        begin
            slots_used = '0;
            answers_due.delete();
            fails = 0;
            bonds_seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                slots_used = cfg_wdata;
            if (req_valid && !req_stall)
            begin
                if (opcode == OP_LOAD_SITE)
                    sites[index_a] = '{x: coord_x, y: coord_y, z: coord_z};
                else if (opcode == OP_LOAD_CLASS && index_a < MAX_CLASSES_DEF)
                    classes[index_a] = '{dmin: class_dmin, dmax: class_dmax,
                                         amin: class_angle_min, amax: class_angle_max};
                else if (opcode == OP_CLASSIFY)
                    answers_due.push_back(classify_pair(index_a, index_b));
            end
            if (rsp_valid && !rsp_stall)
            begin
                got = '{bond: is_bond, slot: bond_slot, length: bond_length,
                        site_a: first_site, site_b: second_site};
                if (is_bond)
                    bonds_seen++;
                if (answers_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word: expected none, got %p", got);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch at %0t: expected %p, got %p",
                                     $realtime, want, got);
                    end
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

[tb/testbench.sv]
// top of the bond classifier testbench: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps
module testbench
    import spbc_pkg::*;
();

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  ia, ib;
        logic [15:0] x, y, z, dmin, dmax;
        logic [12:0] amin, amax;
    } req_word_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [3:0] cfg_wdata = '0;
    logic req_valid = 0;
    logic req_stall;
    logic [1:0] opcode = '0;
    logic [7:0] index_a = '0, index_b = '0;
    logic signed [15:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic [15:0] class_dmin = '0, class_dmax = '0;
    logic [12:0] class_angle_min = '0, class_angle_max = '0;
    logic rsp_valid;
    logic rsp_stall = 0;
    logic is_bond;
    logic [2:0] bond_slot;
    logic [15:0] bond_length;
    logic [7:0] first_site, second_site;

    int fails, pending, bonds_seen;
    int snd_idle = 0, rcv_idle = 0;
    int idle_cycles = 0;
    int n_words = 0, n_pairs = 0;
    bit site_loaded [256];
    byte unsigned loaded_list [$];

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    site_pair_bond_classifier dut (
        .clk, .rst_n, .cfg_we, .cfg_wdata, .req_valid, .req_stall, .opcode,
        .index_a, .index_b, .coord_x, .coord_y, .coord_z, .class_dmin, .class_dmax,
        .class_angle_min, .class_angle_max, .rsp_valid, .rsp_stall, .is_bond,
        .bond_slot, .bond_length, .first_site, .second_site
    );

    bond_checker chk (
        .clk, .rst_n, .cfg_we, .cfg_wdata, .req_valid, .req_stall, .opcode,
        .index_a, .index_b, .coord_x, .coord_y, .coord_z, .class_dmin, .class_dmax,
        .class_angle_min, .class_angle_max, .rsp_valid, .rsp_stall, .is_bond,
        .bond_slot, .bond_length, .first_site, .second_site,
        .fails, .pending, .bonds_seen
    );

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < rcv_idle);

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input req_word_t w);
        while ($urandom_range(99) < snd_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        opcode <= w.op;
        index_a <= w.ia;
        index_b <= w.ib;
        coord_x <= w.x;
        coord_y <= w.y;
        coord_z <= w.z;
        class_dmin <= w.dmin;
        class_dmax <= w.dmax;
        class_angle_min <= w.amin;
        class_angle_max <= w.amax;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        n_words++;
        if (w.op == OP_CLASSIFY)
            n_pairs++;
        if (w.op == OP_LOAD_SITE && !site_loaded[w.ia])
        begin
            site_loaded[w.ia] = 1'b1;
            loaded_list.push_back(w.ia);
        end
    endtask

    // stop sending, drain every answer and let a trailing load finish
    task automatic drain;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_classes_used(input logic [3:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic req_word_t noise_word(input logic [1:0] op);
        req_word_t w;
        w.op = op;
        w.ia = 8'($urandom_range(255));
        w.ib = 8'($urandom_range(255));
        w.x = 16'($urandom); w.y = 16'($urandom); w.z = 16'($urandom);
        w.dmin = 16'($urandom); w.dmax = 16'($urandom);
        w.amin = 13'($urandom); w.amax = 13'($urandom);
        return w;
    endfunction

    function automatic req_word_t site_word(input int idx, input int sx,
                                            input int sy, input int sz);
        req_word_t w;
        w = noise_word(OP_LOAD_SITE);
        w.ia = 8'(idx); w.x = 16'(sx); w.y = 16'(sy); w.z = 16'(sz);
        return w;
    endfunction

    function automatic req_word_t class_word(input int slot, input int d0,
                                             input int d1, input int a0, input int a1);
        req_word_t w;
        w = noise_word(OP_LOAD_CLASS);
        w.ia = 8'(slot); w.dmin = 16'(d0); w.dmax = 16'(d1);
        w.amin = 13'(a0); w.amax = 13'(a1);
        return w;
    endfunction

    function automatic req_word_t pair_word(input int a, input int b);
        req_word_t w;
        w = noise_word(OP_CLASSIFY);
        w.ia = 8'(a); w.ib = 8'(b);
        return w;
    endfunction

    function automatic int rand_coord;
        if ($urandom_range(3) == 0)
            return int'($signed(16'($urandom)));
        return int'($urandom_range(1200)) - 600;
    endfunction

    function automatic req_word_t random_word;
        int pick, d0, a0;
        pick = $urandom_range(99);
        if (pick < 60)
            return pair_word(int'(loaded_list[$urandom_range(loaded_list.size() - 1)]),
                             int'(loaded_list[$urandom_range(loaded_list.size() - 1)]));
        if (pick < 85)
            return site_word(int'($urandom_range(255)), rand_coord(), rand_coord(),
                             rand_coord());
        if (pick < 95)
        begin
            if ($urandom_range(4) == 0)
                return noise_word(OP_LOAD_CLASS);
            d0 = int'($urandom_range(500));
            a0 = int'($urandom_range(5760));
            return class_word(int'($urandom_range(9)), d0, d0 + int'($urandom_range(900)),
                              a0, a0 + int'($urandom_range(3000)));
        end
        return noise_word(OP_NONE);
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_classes_used(4'd0);

        // directed: store extremes, all slots, ignored slot, unused opcode
        send_word(site_word(0, 0, 0, 0));
        send_word(site_word(1, 32767, 32767, 32767));
        send_word(site_word(2, -32768, -32768, -32768));
        send_word(site_word(3, 0, 0, 256));
        send_word(site_word(4, 256, 0, 0));
        send_word(site_word(255, 181, -181, 256));
        send_word(class_word(0, 0, 300, 0, 0));
        send_word(class_word(1, 1000, 65535, 5760, 5760));
        send_word(class_word(2, 0, 65535, 3000, 2000));
        send_word(class_word(3, 0, 400, 0, 5760));
        send_word(class_word(4, 0, 65535, 0, 8191));
        send_word(class_word(5, 400, 300, 0, 5760));
        send_word(class_word(6, 0, 0, 0, 0));
        send_word(class_word(7, 65535, 65535, 5760, 5760));
        send_word(class_word(200, 0, 65535, 0, 5760));
        send_word(noise_word(OP_NONE));
        send_word(pair_word(3, 0));
        drain();
        write_classes_used(4'd8);
        send_word(pair_word(0, 0));
        send_word(pair_word(3, 0));
        send_word(pair_word(4, 0));
        send_word(pair_word(255, 0));
        send_word(pair_word(1, 2));
        send_word(pair_word(2, 1));
        send_word(pair_word(0, 255));

        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            write_classes_used(ph == 0 ? 4'd15 : ph == 1 ? 4'($urandom_range(1, 7)) : 4'd8);
            snd_idle = (ph == 0) ? 25 : (ph == 1) ? 59 : 0;
            rcv_idle = (ph == 0) ? 59 : (ph == 1) ? 25 : 0;
            for (int i = 0; i < 560; i++)
                send_word(random_word());
        end
        drain();

        $display("sent %0d words, %0d site pairs classified, %0d bonds found",
                 n_words, n_pairs, bonds_seen);
        $display("covered class counts 0, 8, 15 and a mid value under three idle mixes");
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
